/* hdl/ps2mt_pkg.sv */
// shared types and constants for the ps2 mouse packet tracker
`default_nettype none
package ps2mt_pkg;

  localparam int BYTE_W   = 8;
  localparam int SIZE_W   = 13;
  localparam int POS_W    = 12;
  localparam int DELTA_W  = 9;
  localparam int STEP_W   = 10;

  // header bit positions
  localparam int HDR_LEFT_BIT = 0;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

  localparam int RESET_X = 512;
  localparam int RESET_Y = 384;
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(768);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_index_t;

  // packet assembler to datapath
  typedef struct packed {
    logic                      done;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic                      left;
  } pkt_t;

  // one result item
  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             left_button;
  } res_t;

endpackage
`default_nettype wire

/* hdl/ps2mt_if.sv */
// valid/ready channel interfaces for the byte input and the position output
`default_nettype none
interface ps2mt_byte_if;
  import ps2mt_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              from_aux;
  modport source (output valid, output data_byte, output from_aux, input ready);
  modport sink (input valid, input data_byte, input from_aux, output ready);
endinterface

interface ps2mt_pos_if;
  import ps2mt_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             left_button;
  modport source (output valid, output pos_x, output pos_y, output left_button, input ready);
  modport sink (input valid, input pos_x, input pos_y, input left_button, output ready);
endinterface
`default_nettype wire

/* hdl/ps2mt_packet_asm.sv */
// collects mouse bytes into three-byte packets
`default_nettype none
module ps2mt_packet_asm
  import ps2mt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              from_aux,
  output pkt_t                   pkt
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XMOVE  = 2'd1,
    PH_YMOVE  = 2'd2
  } phase_t;

  phase_t            byte_phase;
  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] x_move_byte;

  // packet completes on the third mouse byte
  always_comb begin
    pkt.done = from_aux && (byte_phase == PH_YMOVE);
    pkt.dx   = {header_byte[HDR_XSIGN_BIT], x_move_byte};
    pkt.dy   = {header_byte[HDR_YSIGN_BIT], data_byte};
    pkt.left = header_byte[HDR_LEFT_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase  <= PH_HEADER;
      header_byte <= '0;
      x_move_byte <= '0;
    end else if (fire && from_aux) begin
      unique case (byte_phase)
        PH_HEADER: begin
          header_byte <= data_byte;
          byte_phase  <= PH_XMOVE;
        end
        PH_XMOVE: begin
          x_move_byte <= data_byte;
          byte_phase  <= PH_YMOVE;
        end
        PH_YMOVE: begin
          byte_phase <= PH_HEADER;
        end
        default: begin
          byte_phase <= PH_HEADER;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/ps2mt_axis_clamp.sv */
// adds a step to one coordinate and clamps it to the screen size
`default_nettype none
module ps2mt_axis_clamp
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0]  cur,
  input  wire logic signed [STEP_W-1:0] step,
  input  wire logic [SIZE_W-1:0]      size,
  output logic [COORD_BITS-1:0]       next_pos
);

  localparam int EW = (COORD_BITS + 2 > SIZE_W + 1) ? COORD_BITS + 2 : SIZE_W + 1;
  localparam logic signed [EW-1:0] RANGE = EW'(1) <<< COORD_BITS;
  localparam logic signed [EW-1:0] ONE   = EW'(1);

  logic signed [EW-1:0] v;
  logic signed [EW-1:0] lim;
  logic signed [EW-1:0] lim_m1;

  always_comb begin
    v = $signed(EW'(cur)) + EW'(step);
    lim = $signed(EW'(size));
    // zero size acts as one, oversize saturates at the coordinate range
    if (lim < ONE) lim = ONE;
    if (lim > RANGE) lim = RANGE;
    lim_m1 = lim - ONE;
    if (v < 0) v = '0;
    if (v >= lim) v = lim_m1;
    next_pos = v[COORD_BITS-1:0];
  end

endmodule
`default_nettype wire

/* hdl/ps2mt_out_skid.sv */
// two-entry output buffer between the datapath and the result channel
`default_nettype none
module ps2mt_out_skid
  import ps2mt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      can_push,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  logic main_valid;
  logic spare_valid;
  res_t main_data;
  res_t spare_data;
  logic pop;

  assign can_push  = !spare_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        main_data   <= spare_data;
        spare_valid <= 1'b0;
      end else if (push) begin
        main_data <= push_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        spare_data  <= push_data;
        spare_valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/ps2mt_top_core.sv */
// ps2 mouse packet tracker top level: config registers, pointer state and output
`default_nettype none
// Takes one byte per cycle from a PS/2 controller (from_aux marks mouse bytes;
// keyboard bytes are dropped without disturbing packet assembly) and groups
// mouse bytes into three-byte packets. On the third byte the signed X and Y
// movement is applied to the pointer (Y subtracted, screen Y grows downward)
// and each axis is clamped to 0 .. screen size - 1; a zero size acts as one.
// Each packet pushes one position/left-button transaction into the output
// buffer as its third byte is taken. The block takes one byte every cycle: the
// whole update is a single add and clamp per axis between the current position
// and a two-entry output buffer, which stops input only when both entries are
// full. The pointer resets to 512,384 and the screen to 1024 x 768.
module ps2_mouse_packet_tracker_core
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  ps2mt_byte_if.sink             in_ch,
  ps2mt_pos_if.source            out_ch,
  input  wire logic              cfg_wr_en,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0]     screen_width;
  logic [SIZE_W-1:0]     screen_height;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] cur_x_next;
  logic [COORD_BITS-1:0] cur_y_next;

  logic                  in_fire;
  logic                  can_push;
  pkt_t                  pkt;
  logic signed [STEP_W-1:0] step_x;
  logic signed [STEP_W-1:0] step_y;
  res_t                  res;
  res_t                  out_res;

  // byte transaction completes whenever the output buffer has a free entry
  assign in_ch.ready = can_push;
  assign in_fire     = in_ch.valid && can_push;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ps2mt_packet_asm u_asm (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .data_byte (in_ch.data_byte),
    .from_aux  (in_ch.from_aux),
    .pkt       (pkt)
  );

  // x adds the movement, y subtracts it
  assign step_x = STEP_W'(pkt.dx);
  assign step_y = -STEP_W'(pkt.dy);

  ps2mt_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .cur      (cur_x),
    .step     (step_x),
    .size     (screen_width),
    .next_pos (cur_x_next)
  );

  ps2mt_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .cur      (cur_y),
    .step     (step_y),
    .size     (screen_height),
    .next_pos (cur_y_next)
  );

  // pointer state moves only on a completed packet
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= COORD_BITS'(RESET_X);
      cur_y <= COORD_BITS'(RESET_Y);
    end else if (in_fire && pkt.done) begin
      cur_x <= cur_x_next;
      cur_y <= cur_y_next;
    end
  end

  // fit the coordinate width to the fixed output field
  generate
    if (COORD_BITS >= POS_W) begin : g_pos_trunc
      assign res.pos_x = cur_x_next[POS_W-1:0];
      assign res.pos_y = cur_y_next[POS_W-1:0];
    end else begin : g_pos_ext
      assign res.pos_x = {{(POS_W-COORD_BITS){1'b0}}, cur_x_next};
      assign res.pos_y = {{(POS_W-COORD_BITS){1'b0}}, cur_y_next};
    end
  endgenerate
  assign res.left_button = pkt.left;

  ps2mt_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && pkt.done),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.pos_x       = out_res.pos_x;
  assign out_ch.pos_y       = out_res.pos_y;
  assign out_ch.left_button = out_res.left_button;

endmodule
`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the ps2 mouse packet tracker core
module testbench;
  import ps2mt_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int BYTE_SPAN    = 1 << BYTE_W;     // sign extension offset of a movement byte
  localparam int HOLD_CYCLES  = 64;              // long output hold-off for the backpressure test
  localparam int STALL_LIMIT  = 1000;            // cycles with no transaction before giving up
  localparam int PRINT_CAP    = 100;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES  = 90;              // mouse bytes per random phase

  // which packet byte the tracker expects next
  typedef enum logic [1:0] {
    WAIT_HDR,
    WAIT_X,
    WAIT_Y
  } pkt_phase_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [0:0]        cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  ps2mt_byte_if byte_ch ();
  ps2mt_pos_if  pos_ch ();

  ps2_mouse_packet_tracker_core #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (byte_ch),
    .out_ch   (pos_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // pointer tracker mirror: packet assembly, pointer and screen size
  pkt_phase_t              pkt_phase;
  logic [BYTE_W-1:0]       hdr_q;
  logic [BYTE_W-1:0]       xmove_q;
  logic [COORD_BITS-1:0]   ptr_x;
  logic [COORD_BITS-1:0]   ptr_y;
  logic                    btn_q;
  logic [SIZE_W-1:0]       scr_w;
  logic [SIZE_W-1:0]       scr_h;

  // positions still owed by the block, oldest first
  res_t pos_expect_q[$];

  int err_cnt;
  bit gaps_on;    // random idling on both channels
  bit hold_req;   // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // clamp one axis into 0 .. size-1; a zero size acts as one and the
  // limit saturates at the coordinate range
  function automatic logic [COORD_BITS-1:0] fit_axis(input int v, input logic [SIZE_W-1:0] size);
    int top;
    top = int'(size);
    if (top < 1) top = 1;
    if (top > (1 << COORD_BITS)) top = 1 << COORD_BITS;
    if (v < 0) v = 0;
    if (v >= top) v = top - 1;
    return COORD_BITS'(v);
  endfunction

  task automatic reset_tracker();
    pkt_phase = WAIT_HDR;
    hdr_q     = '0;
    xmove_q   = '0;
    ptr_x     = COORD_BITS'(RESET_X);
    ptr_y     = COORD_BITS'(RESET_Y);
    btn_q     = 1'b0;
    scr_w     = RESET_WIDTH;
    scr_h     = RESET_HEIGHT;
  endtask

  // advance the mirror by one accepted byte, queue the position on a full packet
  task automatic track_byte(input logic [BYTE_W-1:0] b, input logic aux);
    int   dx;
    int   dy;
    res_t r;
    if (!aux) return;   // keyboard bytes leave packet assembly alone
    case (pkt_phase)
      WAIT_HDR: begin
        hdr_q     = b;
        pkt_phase = WAIT_X;
      end
      WAIT_X: begin
        xmove_q   = b;
        pkt_phase = WAIT_Y;
      end
      default: begin
        pkt_phase = WAIT_HDR;
        dx = int'(xmove_q);
        dy = int'(b);
        if (hdr_q[HDR_XSIGN_BIT]) dx -= BYTE_SPAN;
        if (hdr_q[HDR_YSIGN_BIT]) dy -= BYTE_SPAN;
        btn_q = hdr_q[HDR_LEFT_BIT];
        ptr_x = fit_axis(int'(ptr_x) + dx, scr_w);
        ptr_y = fit_axis(int'(ptr_y) - dy, scr_h);   // screen y grows downward
        r.pos_x       = POS_W'(ptr_x);
        r.pos_y       = POS_W'(ptr_y);
        r.left_button = btn_q;
        pos_expect_q.push_back(r);
      end
    endcase
  endtask

  // offer one byte and hold it until the block takes it; valid is left high
  // so that a following byte with no gap goes out in the next cycle
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic aux);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.from_aux  <= aux;
    taken = 1'b0;
    // inputs only move at rising edges, so ready seen at the falling edge
    // is what the next rising edge acts on
    while (!taken) begin
      @(negedge clk);
      taken = byte_ch.ready;
      @(posedge clk);
    end
    track_byte(b, aux);
  endtask

  // stop offering, let every owed position come out, then let the
  // pipeline settle
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (pos_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both size registers, one write each; only called with the block idle
  task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    scr_w = w;
    scr_h = h;
  endtask

  // first packet after reset moves nothing: pointer must sit at the reset spot
  task automatic test_reset_position();
    send_byte(8'h08, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    drain();
  endtask

  // keyboard bytes alone and wedged between the bytes of one packet
  task automatic test_keyboard_bytes();
    send_byte(8'hFA, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();
  endtask

  // largest moves both ways, both sign bits, all-ones header
  task automatic test_movement_extremes();
    send_byte(8'h31, 1'b1);   // -256 in x, +256 down in y
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);   // -1 on both axes
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);   // +255 in x, 127 up in y
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b1);
    drain();
  endtask

  // zero size pins the pointer at the origin, oversize saturates the range
  task automatic test_screen_extremes();
    set_screen('0, '0);
    send_byte(8'h09, 1'b1);
    send_byte(8'h40, 1'b1);
    send_byte(8'h40, 1'b1);
    drain();
    set_screen('1, '1);
    send_byte(8'h20, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    drain();
  endtask

  // receiver holds off for a long stretch while bytes keep coming, so the
  // output buffer fills and the input side has to stall
  task automatic test_output_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (30) send_byte(BYTE_W'($urandom), 1'b1);
    drain();
    gaps_on = 1'b1;
  endtask

  // random packets over several screen sizes; headers lean toward one
  // direction per phase so the pointer runs into the clamps
  task automatic test_random_traffic();
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [BYTE_W-1:0] b;
    int                drift_x;
    int                drift_y;
    int                sent;
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0: begin w = RESET_WIDTH;                       h = RESET_HEIGHT;                      end
        1: begin w = SIZE_W'($urandom_range(1, 64));    h = SIZE_W'($urandom_range(1, 64));    end
        2: begin w = '1;                                h = '1;                                end
        3: begin w = SIZE_W'(4096);                     h = SIZE_W'(4096);                     end
        4: begin w = SIZE_W'($urandom_range(1, 4096));  h = SIZE_W'($urandom_range(1, 4096));  end
        5: begin w = SIZE_W'(1);                        h = SIZE_W'(2);                        end
        6: begin w = SIZE_W'(4097);                     h = SIZE_W'(1);                        end
        default: begin w = SIZE_W'($urandom_range(4097, 8191)); h = '0;                        end
      endcase
      drain();
      set_screen(w, h);
      gaps_on = (k != 2) && (k != 6);   // two phases run with no idling at all
      drift_x = int'($urandom_range(0, 2)) - 1;
      drift_y = int'($urandom_range(0, 2)) - 1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        b = BYTE_W'($urandom);
        if ($urandom_range(0, 99) < 10) begin
          send_byte(b, 1'b0);   // keyboard noise
        end else begin
          if (pkt_phase == WAIT_HDR) begin
            if (drift_x != 0 && $urandom_range(0, 3) != 0) b[HDR_XSIGN_BIT] = (drift_x < 0);
            if (drift_y != 0 && $urandom_range(0, 3) != 0) b[HDR_YSIGN_BIT] = (drift_y > 0);
          end
          send_byte(b, 1'b1);
          sent++;
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // output receiver: random stalls plus the one long hold-off on request
  initial begin : pos_receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    pos_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pos_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pos_ch.ready <= 1'b0;
      end else begin
        pos_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // every position transaction against the oldest owed position
  initial begin : pos_check
    res_t got;
    res_t want;
    forever begin
      @(negedge clk);
      if (!rst && pos_ch.valid && pos_ch.ready) begin
        got.pos_x       = pos_ch.pos_x;
        got.pos_y       = pos_ch.pos_y;
        got.left_button = pos_ch.left_button;
        if (pos_expect_q.size() == 0) begin
          report_mismatch($sformatf("position %0d,%0d with none pending", got.pos_x, got.pos_y));
        end else begin
          want = pos_expect_q.pop_front();
          if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
          if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
          if (got.left_button !== want.left_button)
            report_mismatch($sformatf("left_button got %0b want %0b",
                                      got.left_button, want.left_button));
        end
      end
    end
  end

  // ends the run once neither channel has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (pos_ch.valid && pos_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : main_seq
    err_cnt  = 0;
    gaps_on  = 1'b1;
    hold_req = 1'b0;
    reset_tracker();
    rst               <= 1'b1;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.from_aux  <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_SCREEN_WIDTH;
    cfg_data          <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_position();
    test_keyboard_bytes();
    test_movement_extremes();
    test_screen_extremes();
    test_output_backpressure();
    test_random_traffic();

    drain();
    repeat (6) @(posedge clk);
    if (err_cnt == 0 && pos_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ps2mt_pkg.sv
hdl/ps2mt_if.sv
hdl/ps2mt_packet_asm.sv
hdl/ps2mt_axis_clamp.sv
hdl/ps2mt_out_skid.sv
hdl/ps2mt_top_core.sv
verif/testbench.sv
